FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the interpolation table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks in the same cycle: antecedent implies consequent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Delayed check: antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tli_pkg.sv
// Types, constants and codes shared by the interpolation table modules.
package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 9;
    localparam int VALUE_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int DIV_STEPS   = 2 * VALUE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_SIZE = 1'b0,
        CFG_LIMIT      = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RANGE_INSIDE = 2'd0,
        RANGE_BELOW  = 2'd1,
        RANGE_ABOVE  = 2'd2
    } t_range;

    typedef enum logic [2:0] {
        ADDR_LAST,
        ADDR_ZERO,
        ADDR_ONE,
        ADDR_PREV_LAST,
        ADDR_MID,
        ADDR_FIRST,
        ADDR_FIRST_M1
    } t_addr_sel;

    typedef enum logic [1:0] {
        RES_LOWER,
        RES_UPPER,
        RES_INTERP
    } t_res_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_LAST,
        S_LD_FIRST,
        S_CLASS,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_LD_PREV,
        S_LD_BOT,
        S_LD_UP,
        S_PREP,
        S_MUL,
        S_DIV,
        S_OUT_LO,
        S_OUT_HI,
        S_OUT_INT
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] key;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_addr_sel addr_sel;
        logic      latch_x;
        logic      ld_lower;
        logic      ld_upper;
        logic      set_status;
        t_range    status;
        logic      srch_init;
        logic      srch_step;
        logic      prep;
        logic      mul;
        logic      div_step;
        logic      out_load;
        t_res_sel  res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic n_is_one;
        logic x_lt_kl;
        logic x_lt_ku;
        logic limit;
        logic count_zero;
        logic first_zero;
        logic div_last;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: rtl/tli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tli_ctrl.sv
// Lookup sequencer: walks the table reads, the search, the multiply, the divide and the result load.
module tli_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_lookup,
    output logic               o_in_ready,
    input  tli_pkg::t_dp_stat  i_stat,
    output tli_pkg::t_dp_cmd   o_cmd
);

    import tli_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_in_valid && i_in_lookup) begin
                    n_state = S_LD_LAST;
                end
            end
            S_LD_LAST:  n_state = S_LD_FIRST;
            S_LD_FIRST: n_state = S_CLASS;
            S_CLASS: begin
                if (i_stat.n_is_one) begin
                    n_state = S_OUT_LO;
                end else if (!i_stat.x_lt_ku) begin
                    n_state = i_stat.limit ? S_OUT_HI : S_LD_PREV;
                end else if (i_stat.x_lt_kl) begin
                    n_state = i_stat.limit ? S_OUT_LO : S_LD_UP;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD:  n_state = i_stat.count_zero ? S_SRCH_END : S_SRCH_CMP;
            S_SRCH_CMP: n_state = S_SRCH_RD;
            S_SRCH_END: n_state = i_stat.first_zero ? S_OUT_LO : S_LD_BOT;
            S_LD_PREV:  n_state = S_PREP;
            S_LD_BOT:   n_state = S_LD_UP;
            S_LD_UP:    n_state = S_PREP;
            S_PREP:     n_state = S_MUL;
            S_MUL:      n_state = S_DIV;
            S_DIV:      n_state = i_stat.div_last ? S_OUT_INT : S_DIV;
            S_OUT_LO, S_OUT_HI, S_OUT_INT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_LAST;
        o_cmd.status   = RANGE_INSIDE;
        o_cmd.res_sel  = RES_LOWER;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.latch_x = i_in_valid && i_in_lookup;
            end
            S_LD_LAST: begin
                o_cmd.ld_upper = 1'b1;
                o_cmd.addr_sel = ADDR_ZERO;
            end
            S_LD_FIRST: begin
                o_cmd.ld_lower = 1'b1;
            end
            S_CLASS: begin
                o_cmd.set_status = 1'b1;
                o_cmd.addr_sel   = i_stat.x_lt_ku ? ADDR_ONE : ADDR_PREV_LAST;
                if (i_stat.n_is_one) begin
                    o_cmd.status = i_stat.x_lt_kl ? RANGE_BELOW : RANGE_ABOVE;
                end else if (!i_stat.x_lt_ku) begin
                    o_cmd.status = RANGE_ABOVE;
                end else if (i_stat.x_lt_kl) begin
                    o_cmd.status = RANGE_BELOW;
                end else begin
                    o_cmd.status    = RANGE_INSIDE;
                    o_cmd.srch_init = 1'b1;
                end
            end
            S_SRCH_RD: begin
                o_cmd.addr_sel = ADDR_MID;
            end
            S_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
            end
            S_SRCH_END: begin
                o_cmd.addr_sel = ADDR_FIRST_M1;
            end
            S_LD_PREV: begin
                o_cmd.ld_lower = 1'b1;
            end
            S_LD_BOT: begin
                o_cmd.ld_lower = 1'b1;
                o_cmd.addr_sel = ADDR_FIRST;
            end
            S_LD_UP: begin
                o_cmd.ld_upper = 1'b1;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_OUT_LO: begin
                o_cmd.out_load = !i_stat.out_busy;
                o_cmd.res_sel  = RES_LOWER;
            end
            S_OUT_HI: begin
                o_cmd.out_load = !i_stat.out_busy;
                o_cmd.res_sel  = RES_UPPER;
            end
            S_OUT_INT: begin
                o_cmd.out_load = !i_stat.out_busy;
                o_cmd.res_sel  = RES_INTERP;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/tli_dp.sv
// Datapath: configuration, entry registers, search indices, multiplier, divider, output.
module tli_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tli_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tli_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [tli_pkg::VALUE_W-1:0]  i_query,
    output logic [tli_pkg::IDX_W-1:0]           o_raddr,
    input  tli_pkg::t_entry                     i_rdata,
    input  tli_pkg::t_dp_cmd                    i_cmd,
    output tli_pkg::t_dp_stat                   o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tli_pkg::VALUE_W-1:0]  o_out_value,
    output logic [1:0]                          o_out_status
);

    import tli_pkg::*;

    localparam int W = VALUE_W;
    localparam logic signed [W+1:0] SUM_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SUM_MIN = {3'b111, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    // Configuration registers.
    logic [SIZE_W-1:0] r_table_size;
    logic              r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_W'(1);
            r_limit      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TABLE_SIZE: r_table_size <= SIZE_W'(i_cfg_data);
                CFG_LIMIT:      r_limit      <= i_cfg_data[0];
                default:        r_limit      <= r_limit;
            endcase
        end
    end

    // Effective entry count, one to the table depth.
    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] n_m1;
    logic [SIZE_W-1:0] n_m2;

    always_comb begin
        if (r_table_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(TABLE_DEPTH)) begin
            n_eff = SIZE_W'(TABLE_DEPTH);
        end else begin
            n_eff = r_table_size;
        end
    end

    assign n_m1 = n_eff - SIZE_W'(1);
    assign n_m2 = n_eff - SIZE_W'(2);

    // Query and bracketing entries.
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_kl;
    logic signed [W-1:0] r_vl;
    logic signed [W-1:0] r_ku;
    logic signed [W-1:0] r_vu;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_x) begin
            r_x <= i_query;
        end
        if (i_cmd.ld_lower) begin
            r_kl <= i_rdata.key;
            r_vl <= i_rdata.value;
        end
        if (i_cmd.ld_upper) begin
            r_ku <= i_rdata.key;
            r_vu <= i_rdata.value;
        end
    end

    // Lower-bound search over [first, first + count).
    logic [SIZE_W-1:0] r_first;
    logic [SIZE_W-1:0] r_count;
    logic [SIZE_W-1:0] half;
    logic [SIZE_W-1:0] mid;
    logic [SIZE_W-1:0] first_eff;
    logic [SIZE_W-1:0] first_m1;

    assign half      = r_count >> 1;
    assign mid       = r_first + half;
    assign first_eff = (r_first >= n_eff) ? n_m1 : r_first;
    assign first_m1  = first_eff - SIZE_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_first <= '0;
            r_count <= n_eff;
        end else if (i_cmd.srch_step) begin
            if (i_rdata.key < r_x) begin
                r_first <= mid + SIZE_W'(1);
                r_count <= r_count - half - SIZE_W'(1);
            end else begin
                r_count <= half;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_LAST:      o_raddr = n_m1[IDX_W-1:0];
            ADDR_ZERO:      o_raddr = '0;
            ADDR_ONE:       o_raddr = IDX_W'(1);
            ADDR_PREV_LAST: o_raddr = n_m2[IDX_W-1:0];
            ADDR_MID:       o_raddr = mid[IDX_W-1:0];
            ADDR_FIRST:     o_raddr = first_eff[IDX_W-1:0];
            ADDR_FIRST_M1:  o_raddr = first_m1[IDX_W-1:0];
            default:        o_raddr = '0;
        endcase
    end

    // Signed differences as sign and magnitude.
    function automatic logic [W:0] sdiff(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b);
        logic [W:0] d;
        logic [W:0] nd;
        d  = {a[W-1], a} - {b[W-1], b};
        nd = -d;
        return d[W] ? {1'b1, nd[W-1:0]} : {1'b0, d[W-1:0]};
    endfunction

    logic [W:0] dk_full;
    logic [W:0] dy_full;
    logic [W:0] dx_full;

    assign dk_full = sdiff(r_ku, r_kl);
    assign dy_full = sdiff(r_vu, r_vl);
    assign dx_full = sdiff(r_x, r_kl);

    logic         r_nk;
    logic         r_ny;
    logic         r_nx;
    logic [W-1:0] r_dk;
    logic [W-1:0] r_dy;
    logic [W-1:0] r_dx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_nk <= dk_full[W];
            r_ny <= dy_full[W];
            r_nx <= dx_full[W];
            r_dk <= dk_full[W-1:0];
            r_dy <= dy_full[W-1:0];
            r_dx <= dx_full[W-1:0];
        end
    end

    // Restoring divider, one quotient bit a cycle; the quotient shifts into r_num.
    logic [2*W-1:0]     r_num;
    logic [W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [W:0]         trial;
    logic [W:0]         trial_sub;
    logic               trial_ge;

    assign trial     = {r_rem, r_num[2*W-1]};
    assign trial_ge  = trial >= {1'b0, r_dk};
    assign trial_sub = trial - {1'b0, r_dk};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num     <= r_dy * r_dx;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
            r_num     <= {r_num[2*W-2:0], trial_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // Final add or subtract of the quotient, saturated.
    logic                neg;
    logic signed [W+1:0] vl_ext;
    logic signed [W+1:0] q_ext;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] interp_val;

    assign neg    = r_ny ^ r_nx ^ r_nk;
    assign vl_ext = {{2{r_vl[W-1]}}, r_vl};
    assign q_ext  = {2'b00, r_num[W-1:0]};
    assign sum    = neg ? (vl_ext - q_ext) : (vl_ext + q_ext);

    always_comb begin
        if (r_dk == '0 || r_num == '0) begin
            interp_val = r_vl;
        end else if (r_num[2*W-1:W] != '0) begin
            interp_val = neg ? VAL_MIN : VAL_MAX;
        end else if (sum > SUM_MAX) begin
            interp_val = VAL_MAX;
        end else if (sum < SUM_MIN) begin
            interp_val = VAL_MIN;
        end else begin
            interp_val = sum[W-1:0];
        end
    end

    // Output register.
    logic                r_out_valid;
    logic signed [W-1:0] r_out_value;
    t_range              r_status;
    t_range              r_out_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            case (i_cmd.res_sel)
                RES_LOWER:  r_out_value <= r_vl;
                RES_UPPER:  r_out_value <= r_vu;
                RES_INTERP: r_out_value <= interp_val;
                default:    r_out_value <= r_vl;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

    assign o_stat.n_is_one   = (n_eff == SIZE_W'(1));
    assign o_stat.x_lt_kl    = r_x < r_kl;
    assign o_stat.x_lt_ku    = r_x < r_ku;
    assign o_stat.limit      = r_limit;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.first_zero = (first_eff == '0);
    assign o_stat.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

endmodule

FILE: rtl/table_linear_interpolation.sv
// Piecewise linear interpolation table: top level with stream ports and configuration port.
//
// A write word (tuser 0) stores one (key, value) entry in the cycle it is taken. A lookup
// word (tuser 1) reads the table through one RAM read port. Every lookup reads the last and
// the first entry and classifies the query, which settles a clamped or single-entry result.
// A query inside the table runs a binary search of two to nine probes, each a read and a
// compare on the shared read port, closed by a last read and an end step; a result at the
// first entry is loaded from there. Else the missing bracketing entries are read, and the
// product of the differences passes the bit-serial divider (one quotient bit a cycle). The
// block takes no new word while a lookup is in progress and is ready again in the cycle
// after the result is loaded; a finished result waits in the output register and the next
// word is accepted meanwhile, while a later lookup holds its result back until that
// register is free. The table holds no reset value, so every entry within table_size must
// be written before it is looked up. Keys must ascend.
`include "assert_macros.svh"
module table_linear_interpolation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [tli_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tli_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input words.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [71:0]                    s_axis_tdata,  // entry_index, key_value, entry_value
    input  logic [0:0]                     s_axis_tuser,  // action
    // Result words.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // interp_value
    output logic [1:0]                     m_axis_tuser   // range_status
);

    import tli_pkg::*;

    logic [IDX_W-1:0]         in_index;
    logic signed [VALUE_W-1:0] in_key;
    logic signed [VALUE_W-1:0] in_value;
    logic                     in_lookup;
    logic                     in_ready;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    t_entry                   ram_wdata;
    t_entry                   ram_rdata;
    t_dp_cmd                  cmd;
    t_dp_stat                 stat;

    assign in_index  = s_axis_tdata[IDX_W-1:0];
    assign in_key    = s_axis_tdata[IDX_W+VALUE_W-1:IDX_W];
    assign in_value  = s_axis_tdata[IDX_W+2*VALUE_W-1:IDX_W+VALUE_W];
    assign in_lookup = (s_axis_tuser[0] == ACT_LOOKUP);

    assign s_axis_tready = in_ready;
    assign ram_we        = s_axis_tvalid && in_ready && !in_lookup;
    assign ram_wdata     = '{key: in_key, value: in_value};

    tli_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_index),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_lookup (in_lookup),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tli_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_query      (in_key),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_value  (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

    // A lookup holds off further input words until it has finished.
    `ASSERT_NEXT(a_lookup_blocks_input, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && in_lookup, !s_axis_tready)
    // A new result is only produced as the sequencer returns to idle.
    `ASSERT_IMPLY(a_result_at_finish, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready)
    // The range code of a result is one of the three defined codes.
    `ASSERT_IMPLY(a_range_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser == RANGE_INSIDE || m_axis_tuser == RANGE_BELOW || m_axis_tuser == RANGE_ABOVE)

endmodule

FILE: verif/table_linear_interpolation_tb.sv
// Self-checking testbench for the interpolation table: directed and random words against a built-in predictor.
module table_linear_interpolation_tb;
    import tli_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_WORDS   = 70;
    localparam logic signed [31:0]  KEY_MIN = 32'h8000_0000;
    localparam logic signed [31:0]  KEY_MAX = 32'h7FFF_FFFF;
    localparam logic signed [127:0] SAT_HI  = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO  = -SAT_HI - 128'sd1;

    typedef struct packed {
        logic signed [31:0] value;
        t_range             status;
    } t_lookup_result;

    typedef enum int {KEYS_FULL, KEYS_CLOSE, KEYS_SPREAD, KEYS_UNSORTED} t_key_spread;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RARE} t_rx_pattern;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [71:0]           s_axis_tdata  = '0;  // entry_index, key_value, entry_value
    logic [0:0]            s_axis_tuser  = '0;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // interp_value
    logic [1:0]            m_axis_tuser;        // range_status

    // Shadow copy of the table and registers, updated as words are accepted and registers written.
    logic signed [31:0] key_shadow   [TABLE_DEPTH];
    logic signed [31:0] value_shadow [TABLE_DEPTH];
    logic [SIZE_W-1:0]  size_shadow  = 9'd1;
    logic               clamp_shadow = 1'b1;
    t_lookup_result     expected_q [$];

    int fault_count     = 0;
    int writes_sent     = 0;
    int lookups_sent    = 0;
    int results_checked = 0;
    int settings_used   = 1;
    int cycle_count     = 0;
    int tx_gap_max      = 0;
    int tx_burst_left   = 1;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;
    int rx_mode_left    = 0;
    t_rx_pattern rx_mode = RX_ALWAYS;

    table_linear_interpolation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("[table_linear_interpolation] ERROR");
            $finish;
        end
    end

    // Receiver: a changing stall pattern, plus one long hold when the test asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_pattern'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(50, 600);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ($urandom_range(0, 39) == 0);
            endcase
        end
    end

    task automatic note_fault(input string detail);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", detail);
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                note_fault($sformatf("result word with none expected: value %h status %0d",
                                     m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.status)
                    note_fault($sformatf("result %0d: expected value %h status %0d, got %h %0d",
                                         results_checked, want.value, want.status,
                                         m_axis_tdata, m_axis_tuser));
            end
            results_checked++;
        end
    end

    // vl + (vu - vl) * (x - kl) / (ku - kl), quotient truncated toward zero, then saturated.
    function automatic logic signed [31:0] interp_segment(input logic signed [31:0] kl,
                                                         input logic signed [31:0] vl,
                                                         input logic signed [31:0] ku,
                                                         input logic signed [31:0] vu,
                                                         input logic signed [31:0] x);
        longint dk, dy, dx;
        logic [127:0] prod, quot;
        logic signed [127:0] acc;
        logic neg;
        dk = longint'(ku) - longint'(kl);
        if (dk == 0)
            return vl;
        dy   = longint'(vu) - longint'(vl);
        dx   = longint'(x) - longint'(kl);
        neg  = (dy < 0) ^ (dx < 0) ^ (dk < 0);
        prod = {64'd0, (dy < 0) ? -dy : dy} * {64'd0, (dx < 0) ? -dx : dx};
        quot = prod / {64'd0, (dk < 0) ? -dk : dk};
        acc  = {{96{vl[31]}}, vl};
        acc  = neg ? acc - $signed(quot) : acc + $signed(quot);
        if (acc > SAT_HI)
            return KEY_MAX;
        if (acc < SAT_LO)
            return KEY_MIN;
        return acc[31:0];
    endfunction

    function automatic t_lookup_result predict_lookup(input logic signed [31:0] x);
        t_lookup_result r;
        int n, first, count, step, mid;
        n = (size_shadow == 0) ? 1 : (size_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_shadow);
        if (n == 1) begin
            r.value  = value_shadow[0];
            r.status = (x < key_shadow[0]) ? RANGE_BELOW : RANGE_ABOVE;
        end else if (!(x < key_shadow[n-1])) begin
            r.status = RANGE_ABOVE;
            r.value  = clamp_shadow ? value_shadow[n-1]
                     : interp_segment(key_shadow[n-2], value_shadow[n-2],
                                      key_shadow[n-1], value_shadow[n-1], x);
        end else if (x < key_shadow[0]) begin
            r.status = RANGE_BELOW;
            r.value  = clamp_shadow ? value_shadow[0]
                     : interp_segment(key_shadow[0], value_shadow[0],
                                      key_shadow[1], value_shadow[1], x);
        end else begin
            // Lower-bound search: first entry whose key is not below the query.
            r.status = RANGE_INSIDE;
            first = 0;
            count = n;
            while (count > 0) begin
                step = count / 2;
                mid  = first + step;
                if (key_shadow[mid] < x) begin
                    first = mid + 1;
                    count = count - step - 1;
                end else begin
                    count = step;
                end
            end
            if (first >= n)
                first = n - 1;
            if (first == 0)
                r.value = value_shadow[0];
            else
                r.value = interp_segment(key_shadow[first-1], value_shadow[first-1],
                                         key_shadow[first], value_shadow[first], x);
        end
        return r;
    endfunction

    // Offers one word until it is taken, then updates the shadow state and the sender's bursts.
    task automatic send_word(input t_action act, input logic [7:0] idx,
                             input logic signed [31:0] key, input logic signed [31:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {val, key, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_WRITE) begin
            key_shadow[idx]   = key;
            value_shadow[idx] = val;
            writes_sent++;
        end else begin
            expected_q.insert(expected_q.size(), predict_lookup(key));
            lookups_sent++;
        end
        if (tx_gap_max > 0) begin
            tx_burst_left--;
            if (tx_burst_left <= 0) begin
                tx_burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, tx_gap_max);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic send_entry(input logic [7:0] idx, input logic signed [31:0] key,
                              input logic signed [31:0] val);
        send_word(ACT_WRITE, idx, key, val);
    endtask

    // The unused fields of a lookup word carry random bits.
    task automatic send_lookup(input logic signed [31:0] x);
        send_word(ACT_LOOKUP, 8'($urandom), x, $urandom);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TABLE_SIZE)
            size_shadow = data;
        else
            clamp_shadow = data[0];
        @(posedge i_clk);
    endtask

    // Registers change only once every result is back and a write word has had time to settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_table(input int n, input t_key_spread spread, input bit wide_values);
        longint k, span;
        logic signed [31:0] v;
        span = (spread == KEYS_FULL) ? 64'h1_0000_0000 / n :
               (spread == KEYS_CLOSE) ? 64'd3 : 64'd262144;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        if (spread == KEYS_FULL)
            k = longint'(KEY_MIN) + longint'($urandom_range(0, 32'(span)));
        else
            k = longint'($signed($urandom) >>> 2);
        for (int i = 0; i < n; i++) begin
            if (spread == KEYS_UNSORTED)
                k = longint'($signed($urandom));
            else if (i > 0)
                k += longint'($urandom_range(0, 32'(span)));
            if (k > longint'(KEY_MAX))
                k = KEY_MAX;
            v = wide_values ? $urandom : ($signed($urandom) >>> 11);
            send_entry(8'(i), 32'(k), v);
        end
    endtask

    // Mostly lookups around the table's keys, with some entry rewrites and unused-entry writes.
    task automatic random_item(input int n);
        int pick, idx;
        longint lo, hi, t;
        logic signed [31:0] x;
        pick = $urandom_range(0, 99);
        if (pick < 8 && n < TABLE_DEPTH) begin
            send_entry(8'($urandom_range(n, TABLE_DEPTH - 1)), $urandom, $urandom);
        end else if (pick < 13) begin
            idx = $urandom_range(0, n - 1);
            send_entry(8'(idx), key_shadow[idx], $urandom);
        end else begin
            case (pick % 4)
                0: x = $urandom;
                1: x = key_shadow[$urandom_range(0, n - 1)] + 32'($urandom_range(0, 2)) - 32'd1;
                default: begin
                    lo = key_shadow[0];
                    hi = key_shadow[n-1];
                    if (hi < lo) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    lo -= 4096;
                    hi += 4096;
                    t = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
                    if (t < longint'(KEY_MIN))
                        t = KEY_MIN;
                    if (t > longint'(KEY_MAX))
                        t = KEY_MAX;
                    x = 32'(t);
                end
            endcase
            if (pick >= 97)
                x = pick[0] ? KEY_MIN : KEY_MAX;
            send_lookup(x);
        end
    endtask

    // One entry at reset size: below, at and above its key, then a table size of zero.
    task automatic test_single_entry();
        tx_gap_max = 2;
        send_entry(8'd0, 32'h0001_0000, KEY_MIN);
        send_entry(8'd255, KEY_MAX, KEY_MAX);
        send_lookup(KEY_MIN);
        send_lookup(32'h0001_0000);
        send_lookup(KEY_MAX);
        wait_idle();
        cfg_write(CFG_TABLE_SIZE, 9'd0);
        settings_used++;
        send_lookup(32'sd0);
    endtask

    // Three entries: clamping, exact first key, interpolation, then extrapolation and equal keys.
    task automatic test_clamp_and_extrapolate();
        wait_idle();
        cfg_write(CFG_TABLE_SIZE, 9'd3);
        settings_used++;
        send_entry(8'd0, 32'hFFFF_0000, KEY_MAX);
        send_entry(8'd1, 32'h0000_0000, 32'h0000_1234);
        send_entry(8'd2, 32'h0003_0000, KEY_MIN);
        send_lookup(KEY_MIN);
        send_lookup(32'hFFFF_0000);
        send_lookup(32'hFFFF_8000);
        send_lookup(32'h0000_8000);
        send_lookup(32'h0003_0000);
        send_lookup(KEY_MAX);
        wait_idle();
        // Upper data bits set: only bit 0 selects the mode.
        cfg_write(CFG_LIMIT, 9'h1FE);
        settings_used++;
        send_lookup(KEY_MIN);
        send_lookup(KEY_MAX);
        send_entry(8'd2, 32'h0000_0000, 32'h0000_5000);
        send_lookup(32'sd5);
    endtask

    task automatic test_random_tables();
        int sizes [13] = '{2, 0, 5, 256, 17, 1, 3, 511, 8, 64, 2, 33, 6};
        int n;
        t_key_spread spread;
        for (int p = 0; p < 13; p++) begin
            wait_idle();
            cfg_write(CFG_TABLE_SIZE, 9'(sizes[p]));
            cfg_write(CFG_LIMIT, {8'($urandom), (p % 2 == 0) ? 1'b1 : 1'b0});
            settings_used++;
            tx_gap_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 25;
            n = (sizes[p] == 0) ? 1 : (sizes[p] > TABLE_DEPTH) ? TABLE_DEPTH : sizes[p];
            spread = (sizes[p] == 17) ? KEYS_UNSORTED : t_key_spread'(p % 3);
            load_table(n, spread, 1'($urandom_range(0, 1)));
            repeat (PHASE_WORDS) random_item(n);
        end
    endtask

    // Long receiver hold while lookups keep coming, so the block fills up and stops taking words.
    task automatic test_output_stall();
        wait_idle();
        cfg_write(CFG_TABLE_SIZE, 9'd8);
        cfg_write(CFG_LIMIT, 9'd0);
        settings_used++;
        tx_gap_max = 0;
        load_table(8, KEYS_SPREAD, 1'b1);
        hold_req <= hold_req + 1;
        repeat (40) random_item(8);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_entry();
        test_clamp_and_extrapolate();
        test_random_tables();
        test_output_stall();
        wait_idle();
        $display("covered %0d table writes and %0d lookups over %0d register settings",
                 writes_sent, lookups_sent, settings_used);
        $display("%0d results checked, %0d mismatches", results_checked, fault_count);
        if (fault_count == 0)
            $display("[table_linear_interpolation] OK");
        else
            $display("[table_linear_interpolation] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_ctrl.sv
rtl/tli_dp.sv
rtl/table_linear_interpolation.sv
verif/table_linear_interpolation_tb.sv
